### hw/rtl/pfp_pkg.sv
`timescale 1ns / 1ps
package pfp_pkg;

  localparam int OUT_W   = 19;
  localparam int OUT_MAX = (2 ** (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  typedef logic signed [OUT_W-1:0] foot_t;

endpackage

### hw/rtl/pfp_div_cell.sv
`timescale 1ns / 1ps
module pfp_div_cell #(
  parameter int DIV_W  = 33,
  parameter int QUO_W  = 18,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [QUO_W-1:0]  nq_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [QUO_W-1:0]  nq_o,
  output logic [DIV_W-1:0]  div_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  nq_q, nq_d;
  logic [DIV_W-1:0]  div_q;
  logic [SIDE_W-1:0] side_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, nq_i[QUO_W-1]};
    diff  = trial - {1'b0, div_i};
    ge    = trial >= {1'b0, div_i};
    rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    nq_d  = {nq_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      div_q  <= div_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

### hw/rtl/pfp_div_chain.sv
`timescale 1ns / 1ps
module pfp_div_chain #(
  parameter int DIV_W  = 33,
  parameter int QUO_W  = 18,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [QUO_W-1:0]  nq_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [DIV_W-1:0]  div_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_w [QUO_W+1];
  logic [DIV_W-1:0]  rem_w   [QUO_W+1];
  logic [QUO_W-1:0]  nq_w    [QUO_W+1];
  logic [DIV_W-1:0]  div_w   [QUO_W+1];
  logic [SIDE_W-1:0] side_w  [QUO_W+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = rem_i;
  assign nq_w[0]    = nq_i;
  assign div_w[0]   = div_i;
  assign side_w[0]  = side_i;

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    pfp_div_cell #(
      .DIV_W  (DIV_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[i]),
      .rem_i   (rem_w[i]),
      .nq_i    (nq_w[i]),
      .div_i   (div_w[i]),
      .side_i  (side_w[i]),
      .valid_o (valid_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .nq_o    (nq_w[i+1]),
      .div_o   (div_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  assign valid_o = valid_w[QUO_W];
  assign rem_o   = rem_w[QUO_W];
  assign quo_o   = nq_w[QUO_W];
  assign div_o   = div_w[QUO_W];
  assign side_o  = side_w[QUO_W];

endmodule

### hw/rtl/perpendicular_foot_point.sv
`timescale 1ns / 1ps
// throughput: one item per cycle unless the output stalls; set by the fully pipelined
//   datapath and the two chains of divider cells, one quotient bit per cell
// stall: the pipeline holds only while its last stage and the output register are full
//   and the output is not taken
// reset: asynchronous active low, clears all valid bits; the pipeline is empty after reset
module perpendicular_foot_point #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] line_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] line_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] line_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] line_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfp_pkg::foot_t                foot_x_o,
  output pfp_pkg::foot_t                foot_y_o
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = 2 * W + 1;
  localparam int QX  = W + 2;
  localparam int QY  = W + 2;
  localparam int FW  = W + 4;
  localparam int NSW = 3 * W + 3;
  localparam int YSW = 2 * W + 7;
  localparam int SW  = (FW > pfp_pkg::OUT_W) ? FW + 1 : pfp_pkg::OUT_W + 1;

  typedef struct packed {
    logic                general;
    logic signed [W-1:0] spec_x;
    logic signed [W-1:0] spec_y;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic                neg;
  } xside_t;

  typedef struct packed {
    logic                 general;
    logic signed [W-1:0]  spec_x;
    logic signed [W-1:0]  spec_y;
    logic signed [FW-1:0] fx;
    logic                 neg;
  } yside_t;

  localparam int XSIDE_W = $bits(xside_t);
  localparam int YSIDE_W = $bits(yside_t);

  function automatic pfp_pkg::foot_t sat_out(input logic signed [FW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > SW'(pfp_pkg::OUT_MAX)) begin
      e = SW'(pfp_pkg::OUT_MAX);
    end else if (e < SW'(pfp_pkg::OUT_MIN)) begin
      e = SW'(pfp_pkg::OUT_MIN);
    end
    return e[pfp_pkg::OUT_W-1:0];
  endfunction

  logic en;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic vr1_q, vr2_q, vy1_q, vy2_q, vy3_q, vy4_q, vf1_q, vf2_q;
  logic out_valid_q;

  // stage payloads
  xside_t                side1_q, side2_q, side3_q, side4_q, side5_q, side6_q, side1_d;
  xside_t                side6_d;
  logic signed [W:0]     ex_q, ey_q;
  logic signed [2*W+1:0] dxx_q, dyy_q, dxe_q, dye_q;
  logic [DW-1:0]         d3_q, d4_q, d5_q;
  logic signed [2*W+2:0] t_q;
  logic signed [3*W+1:0] pxd_q;
  logic signed [3*W+3:0] pdt_q;
  logic signed [NSW-1:0] n_q;
  logic [DW-1:0]         xrem0_q, xdiv0_q;
  logic [QX-1:0]         xnq0_q;

  logic                  xv;
  logic [DW-1:0]         xr, xd;
  logic [QX-1:0]         xq;
  logic [XSIDE_W-1:0]    xside_raw;
  xside_t                xs;

  xside_t                sider1_q, sider2_q, sidey1_q, sidey2_q, sidey3_q;
  logic [QX:0]           qx_q;
  logic signed [FW-1:0]  fx_q, fxy1_q, fxy2_q, fxy3_q;
  logic signed [FW:0]    u_q;
  logic signed [2*W:0]   p1_q;
  logic signed [2*W+5:0] p2_q;
  logic signed [YSW-1:0] yn_q;
  logic [W-1:0]          yrem0_q, ydiv0_q;
  logic [QY-1:0]         ynq0_q;
  yside_t                side_y4_q, side_y4_d;

  logic                  yv;
  logic [W-1:0]          yr, yd;
  logic [QY-1:0]         yq;
  logic [YSIDE_W-1:0]    yside_raw;
  yside_t                ys;

  yside_t                sidef1_q, sidef2_q;
  logic [QY:0]           qy_q;
  logic signed [FW-1:0]  fy_q;

  pfp_pkg::foot_t        foot_x_q, foot_y_q;

  // combinational helpers
  logic                  x_up, y_up;
  logic                  ngn, yneg;
  logic [NSW-1:0]        nmag;
  logic [YSW-1:0]        ymag;
  logic [W:0]            dxmag;
  logic signed [FW-1:0]  qx_s, qy_s;
  logic signed [2*W+1:0] dsum;
  logic signed [FW-1:0]  sel_x, sel_y;

  assign en         = !(vf2_q && out_valid_q && !out_ready_i);
  assign in_ready_o = en;

  always_comb begin
    side1_d.general = (line_end_x_i != line_start_x_i) && (line_end_y_i != line_start_y_i);
    side1_d.spec_x  = (line_end_x_i == line_start_x_i) ? line_start_x_i : query_x_i;
    side1_d.spec_y  = (line_end_x_i == line_start_x_i) ? query_y_i : line_start_y_i;
    side1_d.x1      = line_start_x_i;
    side1_d.y1      = line_start_y_i;
    side1_d.dx      = (W+1)'(line_end_x_i) - (W+1)'(line_start_x_i);
    side1_d.dy      = (W+1)'(line_end_y_i) - (W+1)'(line_start_y_i);
    side1_d.neg     = 1'b0;
  end

  always_comb begin
    dsum = dxx_q + dyy_q;
    ngn  = n_q[NSW-1];
    nmag = ngn ? NSW'(-n_q) : NSW'(n_q);
  end

  always_comb begin
    side6_d     = side5_q;
    side6_d.neg = ngn;
  end

  assign xs = xside_t'(xside_raw);

  always_comb begin
    x_up = {xr, 1'b0} >= {1'b0, xd};
    qx_s = $signed({1'b0, qx_q});
  end

  always_comb begin
    yneg  = yn_q[YSW-1];
    ymag  = yneg ? YSW'(-yn_q) : YSW'(yn_q);
    dxmag = sidey3_q.dx[W] ? (W+1)'(-sidey3_q.dx) : (W+1)'(sidey3_q.dx);
    side_y4_d.general = sidey3_q.general;
    side_y4_d.spec_x  = sidey3_q.spec_x;
    side_y4_d.spec_y  = sidey3_q.spec_y;
    side_y4_d.fx      = fxy3_q;
    side_y4_d.neg     = yneg ^ sidey3_q.dx[W];
  end

  assign ys = yside_t'(yside_raw);

  always_comb begin
    y_up  = {yr, 1'b0} >= {1'b0, yd};
    qy_s  = $signed({1'b0, qy_q});
    sel_x = sidef2_q.general ? sidef2_q.fx : FW'(sidef2_q.spec_x);
    sel_y = sidef2_q.general ? fy_q : FW'(sidef2_q.spec_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      vr1_q <= 1'b0;
      vr2_q <= 1'b0;
      vy1_q <= 1'b0;
      vy2_q <= 1'b0;
      vy3_q <= 1'b0;
      vy4_q <= 1'b0;
      vf1_q <= 1'b0;
      vf2_q <= 1'b0;
    end else if (en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      vr1_q <= xv;
      vr2_q <= vr1_q;
      vy1_q <= vr2_q;
      vy2_q <= vy1_q;
      vy3_q <= vy2_q;
      vy4_q <= vy3_q;
      vf1_q <= yv;
      vf2_q <= vf1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // differences
      side1_q <= side1_d;
      ex_q    <= (W+1)'(query_x_i) - (W+1)'(line_start_x_i);
      ey_q    <= (W+1)'(query_y_i) - (W+1)'(line_start_y_i);
      // products
      side2_q <= side1_q;
      dxx_q   <= side1_q.dx * side1_q.dx;
      dyy_q   <= side1_q.dy * side1_q.dy;
      dxe_q   <= side1_q.dx * ex_q;
      dye_q   <= side1_q.dy * ey_q;
      // squared length and dot product
      side3_q <= side2_q;
      d3_q    <= dsum[DW-1:0];
      t_q     <= (2*W+3)'(dxe_q) + (2*W+3)'(dye_q);
      // numerator terms
      side4_q <= side3_q;
      d4_q    <= d3_q;
      pxd_q   <= side3_q.x1 * $signed({1'b0, d3_q});
      pdt_q   <= side3_q.dx * t_q;
      // numerator
      side5_q <= side4_q;
      d5_q    <= d4_q;
      n_q     <= NSW'(pxd_q) + $signed(pdt_q[NSW-1:0]);
      // magnitude into the x divider
      side6_q     <= side6_d;
      xrem0_q     <= nmag[NSW-1:QX];
      xnq0_q      <= nmag[QX-1:0];
      xdiv0_q     <= d5_q;
      // x rounding
      sider1_q <= xs;
      qx_q     <= (QX+1)'(xq) + (QX+1)'(x_up);
      sider2_q <= sider1_q;
      fx_q     <= sider1_q.neg ? -qx_s : qx_s;
      // y numerator
      sidey1_q <= sider2_q;
      fxy1_q   <= fx_q;
      u_q      <= (FW+1)'(fx_q) - (FW+1)'(sider2_q.x1);
      sidey2_q <= sidey1_q;
      fxy2_q   <= fxy1_q;
      p1_q     <= sidey1_q.y1 * sidey1_q.dx;
      p2_q     <= sidey1_q.dy * u_q;
      sidey3_q <= sidey2_q;
      fxy3_q   <= fxy2_q;
      yn_q     <= YSW'(p1_q) + YSW'(p2_q);
      // magnitude into the y divider
      side_y4_q <= side_y4_d;
      yrem0_q   <= ymag[QY+W-1:QY];
      ynq0_q    <= ymag[QY-1:0];
      ydiv0_q   <= dxmag[W-1:0];
      // y rounding
      sidef1_q <= ys;
      qy_q     <= (QY+1)'(yq) + (QY+1)'(y_up);
      sidef2_q <= sidef1_q;
      fy_q     <= sidef1_q.neg ? -qy_s : qy_s;
    end
  end

  pfp_div_chain #(
    .DIV_W  (DW),
    .QUO_W  (QX),
    .SIDE_W (XSIDE_W)
  ) u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rem_i   (xrem0_q),
    .nq_i    (xnq0_q),
    .div_i   (xdiv0_q),
    .side_i  (side6_q),
    .valid_o (xv),
    .rem_o   (xr),
    .quo_o   (xq),
    .div_o   (xd),
    .side_o  (xside_raw)
  );

  pfp_div_chain #(
    .DIV_W  (W),
    .QUO_W  (QY),
    .SIDE_W (YSIDE_W)
  ) u_ydiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vy4_q),
    .rem_i   (yrem0_q),
    .nq_i    (ynq0_q),
    .div_i   (ydiv0_q),
    .side_i  (side_y4_q),
    .valid_o (yv),
    .rem_o   (yr),
    .quo_o   (yq),
    .div_o   (yd),
    .side_o  (yside_raw)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && vf2_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vf2_q) begin
      foot_x_q <= sat_out(sel_x);
      foot_y_q <= sat_out(sel_y);
    end
  end

  assign out_valid_o = out_valid_q;
  assign foot_x_o    = foot_x_q;
  assign foot_y_o    = foot_y_q;

endmodule

### hw/rtl/pfp_checker.sv
`timescale 1ns / 1ps
module pfp_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input pfp_pkg::foot_t foot_x_o,
  input pfp_pkg::foot_t foot_y_o
);

  localparam int CNT_W = $clog2(2 * COORD_WIDTH + 24);

  logic [CNT_W-1:0] inflight_q, inflight_d;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      inflight_d = inflight_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(foot_x_o) && $stable(foot_y_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a blocked output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

  // no result without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("result with no item in flight");

endmodule

bind perpendicular_foot_point pfp_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_pfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .foot_x_o    (foot_x_o),
  .foot_y_o    (foot_y_o)
);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int COORD_W    = 16;
  localparam int LATENCY    = 2 * COORD_W + 19;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t qx;
    coord_t qy;
  } query_t;

  typedef struct {
    pfp_pkg::foot_t fx;
    pfp_pkg::foot_t fy;
  } foot_pair_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  coord_t         line_start_x_i;
  coord_t         line_start_y_i;
  coord_t         line_end_x_i;
  coord_t         line_end_y_i;
  coord_t         query_x_i;
  coord_t         query_y_i;
  logic           out_valid_o;
  logic           out_ready_i;
  pfp_pkg::foot_t foot_x_o;
  pfp_pkg::foot_t foot_y_o;

  foot_pair_t expected_feet[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         rx_hold = 0;
  int         rx_stall_left = 0;
  bit         rx_stalls_on = 1'b1;
  bit         tx_gaps_on = 1'b1;

  always #2 clk_i = ~clk_i;

  perpendicular_foot_point #(
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_start_x_i(line_start_x_i),
    .line_start_y_i(line_start_y_i),
    .line_end_x_i  (line_end_x_i),
    .line_end_y_i  (line_end_y_i),
    .query_x_i     (query_x_i),
    .query_y_i     (query_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .foot_x_o      (foot_x_o),
    .foot_y_o      (foot_y_o)
  );

  function automatic longint round_half_away(longint num, longint den);
    longint mag_n;
    longint quo;
    longint rem;
    mag_n = (num < 0) ? -num : num;
    quo   = mag_n / den;
    rem   = mag_n % den;
    if (rem >= den - rem) quo++;
    return (num < 0) ? -quo : quo;
  endfunction

  function automatic pfp_pkg::foot_t clamp_foot(longint v);
    if (v > pfp_pkg::OUT_MAX) return pfp_pkg::foot_t'(pfp_pkg::OUT_MAX);
    if (v < pfp_pkg::OUT_MIN) return pfp_pkg::foot_t'(pfp_pkg::OUT_MIN);
    return pfp_pkg::foot_t'(v);
  endfunction

  function automatic foot_pair_t foot_of_perpendicular(query_t q);
    longint x1, y1, x2, y2, x3, y3;
    longint dx, dy, den, proj, num, fx, fy, yn, yd;
    foot_pair_t res;
    x1 = q.sx;
    y1 = q.sy;
    x2 = q.ex;
    y2 = q.ey;
    x3 = q.qx;
    y3 = q.qy;
    dx = x2 - x1;
    dy = y2 - y1;
    if (dx == 0) begin
      fx = x1;
      fy = y3;
    end else if (dy == 0) begin
      fx = x3;
      fy = y1;
    end else begin
      den  = dx * dx + dy * dy;
      proj = dx * (x3 - x1) + dy * (y3 - y1);
      num  = x1 * den + dx * proj;
      fx   = round_half_away(num, den);
      // y follows from the rounded x, not from the exact foot
      yn   = y1 * dx + dy * (fx - x1);
      yd   = dx;
      if (yd < 0) begin
        yn = -yn;
        yd = -yd;
      end
      fy = round_half_away(yn, yd);
    end
    res.fx = clamp_foot(fx);
    res.fy = clamp_foot(fy);
    return res;
  endfunction

  function automatic query_t mk(int sx, int sy, int ex, int ey, int qx, int qy);
    query_t q;
    q.sx = COORD_W'(sx);
    q.sy = COORD_W'(sy);
    q.ex = COORD_W'(ex);
    q.ey = COORD_W'(ey);
    q.qx = COORD_W'(qx);
    q.qy = COORD_W'(qy);
    return q;
  endfunction

  function automatic coord_t near_coord();
    return COORD_W'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    kind = $urandom_range(0, 11);
    q.sx = COORD_W'($urandom);
    q.sy = COORD_W'($urandom);
    q.ex = COORD_W'($urandom);
    q.ey = COORD_W'($urandom);
    q.qx = COORD_W'($urandom);
    q.qy = COORD_W'($urandom);
    case (kind)
      0: begin
        q.sx = near_coord();
        q.sy = near_coord();
        q.ex = near_coord();
        q.ey = near_coord();
        q.qx = near_coord();
        q.qy = near_coord();
      end
      1: q.ex = q.sx;
      2: q.ey = q.sy;
      3: begin
        q.ex = q.sx;
        q.ey = q.sy;
      end
      4: begin
        q.ex = q.sx + near_coord();
        q.ey = q.sy + near_coord();
      end
      5: begin
        q.qx = q.sx + near_coord();
        q.qy = q.sy + near_coord();
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string what, pfp_pkg::foot_t got, pfp_pkg::foot_t want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_query(query_t q);
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    line_start_x_i = q.sx;
    line_start_y_i = q.sy;
    line_end_x_i   = q.ex;
    line_end_y_i   = q.ey;
    query_x_i      = q.qx;
    query_y_i      = q.qy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_feet.push_back(foot_of_perpendicular(q));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic pace_sender();
    int gap;
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      stop_sending();
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    while (expected_feet.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    query_t cases[$];
    cases.push_back(mk(0, 0, 0, 0, 0, 0));
    cases.push_back(mk(5, -100, 5, 200, -32768, 32767));
    cases.push_back(mk(-32768, 0, -32768, 32767, 32767, -32768));
    cases.push_back(mk(32767, 32767, 32767, 32767, -32768, -32768));
    cases.push_back(mk(-32768, 7, 32767, 7, 123, -32768));
    cases.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
    cases.push_back(mk(0, 0, 1, 1, 1, 0));
    cases.push_back(mk(0, 0, -1, 1, -1, 0));
    cases.push_back(mk(0, 0, 1, -1, -1, 0));
    cases.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767));
    cases.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767));
    cases.push_back(mk(-32768, 32767, 32767, -32767, 0, 0));
    cases.push_back(mk(0, -32768, 1, 32767, 32767, -32768));
    cases.push_back(mk(1, -32768, 0, 32767, -32768, 32767));
    cases.push_back(mk(-32768, 0, 32767, 1, 0, 32767));
    cases.push_back(mk(10, 20, 30, 60, 20, 40));
    cases.push_back(mk(-32768, -32768, -32767, -32767, 32767, -32768));
    cases.push_back(mk(-5, 9, 17, -3, -5, 9));
    cases.push_back(mk(-1, -1, 32767, 32767, -1, 32767));
    cases.push_back(mk(3, 4, -5, 2, -7, 9));
    cases.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767));
    cases.push_back(mk(2, 0, 0, 3, -3, -2));
    foreach (cases[i]) begin
      send_query(cases[i]);
      pace_sender();
    end
    stop_sending();
  endtask

  task automatic test_random_queries(int count);
    repeat (count) begin
      send_query(random_query());
      pace_sender();
    end
    stop_sending();
  endtask

  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold    = 300;
    repeat (100) send_query(random_query());
    stop_sending();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) begin
      send_query(random_query());
      pace_sender();
    end
    stop_sending();
    wait_for_drain();
    repeat (20) begin
      send_query(random_query());
      pace_sender();
    end
    stop_sending();
  endtask

  task automatic test_back_to_back(int count);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (count) send_query(random_query());
    stop_sending();
  endtask

  // receiver: a long hold-off while rx_hold is set, otherwise random stall bursts while enabled
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else if (rx_stall_left > 0) begin
        out_ready_i = 1'b0;
        rx_stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready_i   = 1'b0;
        rx_stall_left = $urandom_range(0, 16);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    foot_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_feet.size() == 0) begin
        $display("[%0t] result with no item pending", $time);
        mismatch_count++;
      end else begin
        want = expected_feet.pop_front();
        if (foot_x_o !== want.fx) report_mismatch("foot_x", foot_x_o, want.fx);
        if (foot_y_o !== want.fy) report_mismatch("foot_y", foot_y_o, want.fy);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    line_start_x_i = '0;
    line_start_y_i = '0;
    line_end_x_i   = '0;
    line_end_y_i   = '0;
    query_x_i      = '0;
    query_y_i      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_queries(900);
    test_output_backpressure();
    test_drain_pause();
    test_back_to_back(100);

    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
